// ===== rtl/srpc_pkg.sv =====
// shared types, constants and tables for the reflector pair center finder
package srpc_pkg;

  // scan and rotation sizing
  localparam int MAX_SAMPLES     = 4096;
  localparam int CORDIC_STEPS    = 16;
  localparam int STEPS_PER_STAGE = 2;
  localparam int CORDIC_STAGES   = (CORDIC_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // field widths
  localparam int INT_W     = 16;
  localparam int RNG_W     = 16;
  localparam int SEP_W     = 12;
  localparam int ANG_W     = 32;
  localparam int STEP_W    = 31;
  localparam int OUT_IDX_W = 12;
  localparam int CTR_W     = 17;

  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int DIST_W = (IDX_W > SEP_W) ? IDX_W : SEP_W;

  // fixed point
  localparam int GAIN_W                = 30;
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
  localparam int FRAC_BITS             = 14;
  localparam int RND_SHIFT             = 16;
  localparam int RMUL_W                = RNG_W + GAIN_W;
  localparam int AMUL_W                = IDX_W + STEP_W;
  localparam int XY_W                  = 34;
  localparam int Z_W                   = 34;
  localparam int SUM_W                 = XY_W + 1;
  localparam int OUT_LIMIT             = 65535;

  localparam int ATAN_W = 30;
  localparam logic [ATAN_W-1:0] ATAN_TAB [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85005780, 30'd42667331,
    30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
    30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
    30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81,       30'd41,
    30'd20,        30'd10,        30'd5,         30'd3,        30'd1,
    30'd1,         30'd0
  };

  // pipeline stage positions
  localparam int ST_SNAP    = 0;
  localparam int ST_MUL     = 1;
  localparam int ST_PREP    = 2;
  localparam int ST_ROT0    = 3;
  localparam int NUM_STAGES = ST_ROT0 + CORDIC_STAGES;

  // register port
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = REG_IDX_W + 2;
  localparam int DATA_W    = 32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_THRESHOLD  = 3'd0,
    REG_SEPARATION = 3'd1,
    REG_START      = 3'd2,
    REG_STEP       = 3'd3,
    REG_FLOOR      = 3'd4,
    REG_CEILING    = 3'd5
  } cfg_reg_t;

  localparam logic [INT_W-1:0]  RST_THRESHOLD  = 16'd8000;
  localparam logic [SEP_W-1:0]  RST_SEPARATION = 12'd10;
  localparam logic [ANG_W-1:0]  RST_START      = 32'd0;
  localparam logic [STEP_W-1:0] RST_STEP       = 31'd0;
  localparam logic [RNG_W-1:0]  RST_FLOOR      = 16'd0;
  localparam logic [RNG_W-1:0]  RST_CEILING    = 16'd65535;

  typedef struct packed {
    logic [INT_W-1:0]  thresh_level;
    logic [SEP_W-1:0]  leg_separation;
    logic [ANG_W-1:0]  start_angle;
    logic [STEP_W-1:0] angle_step;
    logic [RNG_W-1:0]  range_floor;
    logic [RNG_W-1:0]  range_ceiling;
  } cfg_t;

  // what travels beside the coordinate math
  typedef struct packed {
    logic             det;
    logic [IDX_W-1:0] i1;
    logic [IDX_W-1:0] i2;
  } side_t;

  // end-of-scan capture
  typedef struct packed {
    side_t            side;
    logic [RNG_W-1:0] r1;
    logic [RNG_W-1:0] r2;
  } snap_t;

endpackage

// ===== rtl/scan_reflector_pair_center.sv =====
// top level of the reflector pair center finder
// throughput: one scan sample per cycle, and one result per cycle when every sample ends a scan
//   while results are taken; a sample marked last reaches the result register through the
//   snap, multiply, prep and rotation stages, the rotation pipeline doing two steps per stage
// a stalled result only holds the input back once every pipeline stage is occupied
// reset: registers return to their defaults, the scan restarts at sample zero, pipeline empties
module scan_reflector_pair_center
  import srpc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  // sample channel
  input  logic                    sample_valid,
  output logic                    sample_ready,
  input  logic [INT_W-1:0]        intensity,
  input  logic [RNG_W-1:0]        range_mm,
  input  logic                    range_finite,
  input  logic                    last_sample,
  // result channel
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic                    detected,
  output logic signed [CTR_W-1:0] center_x,
  output logic signed [CTR_W-1:0] center_y,
  output logic [OUT_IDX_W-1:0]    first_index,
  output logic [OUT_IDX_W-1:0]    second_index
);

  cfg_t  cfg;
  snap_t snap;
  logic  accept;

  srpc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // a sample transaction
  assign accept = sample_valid && sample_ready;

  // leg search; snap shows the scan as it stands with this sample included
  srpc_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .intensity    (intensity),
    .range_mm     (range_mm),
    .range_finite (range_finite),
    .last_sample  (last_sample),
    .cfg          (cfg),
    .snap         (snap)
  );

  // pipeline occupancy and load enables
  // a stage loads when it is empty or its content moves on in the same cycle,
  // so bubbles collapse and the input keeps flowing behind a stalled result
  logic [NUM_STAGES-1:0] v;
  logic [NUM_STAGES-1:0] ld;
  logic                  ld_out;

  always_comb begin
    ld_out             = !result_valid || result_ready;
    ld[NUM_STAGES-1]   = !v[NUM_STAGES-1] || ld_out;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  assign sample_ready = ld[ST_SNAP];

  // only samples that close a scan occupy the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[ST_SNAP]) begin
        v[ST_SNAP] <= accept && last_sample;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (ld[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // detection flag and leg indices ride alongside the coordinate math
  side_t            side [NUM_STAGES];
  logic [RNG_W-1:0] r1_s0, r2_s0;

  always_ff @(posedge clk) begin
    if (ld[ST_SNAP]) begin
      side[ST_SNAP] <= snap.side;
      r1_s0         <= snap.r1;
      r2_s0         <= snap.r2;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (ld[k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  // one conversion lane per leg
  logic signed [XY_W-1:0] x1, y1, x2, y2;

  srpc_polar u_leg1 (
    .clk      (clk),
    .ld       (ld),
    .cfg      (cfg),
    .range_mm (r1_s0),
    .index    (side[ST_SNAP].i1),
    .x        (x1),
    .y        (y1)
  );

  srpc_polar u_leg2 (
    .clk      (clk),
    .ld       (ld),
    .cfg      (cfg),
    .range_mm (r2_s0),
    .index    (side[ST_SNAP].i2),
    .x        (x2),
    .y        (y2)
  );

  // midpoint in millimetres
  logic signed [CTR_W-1:0] mid_x, mid_y;

  srpc_mid u_mid_x (
    .a   (x1),
    .b   (x2),
    .mid (mid_x)
  );

  srpc_mid u_mid_y (
    .a   (y1),
    .b   (y2),
    .mid (mid_y)
  );

  // result register; a scan without detection reports all zero fields
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ld_out) begin
      result_valid <= v[NUM_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      detected <= side[NUM_STAGES-1].det;
      if (side[NUM_STAGES-1].det) begin
        center_x     <= mid_x;
        center_y     <= mid_y;
        first_index  <= OUT_IDX_W'(side[NUM_STAGES-1].i1);
        second_index <= OUT_IDX_W'(side[NUM_STAGES-1].i2);
      end else begin
        center_x     <= '0;
        center_y     <= '0;
        first_index  <= '0;
        second_index <= '0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_detect_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !detected |->
      center_x == '0 && center_y == '0 && first_index == '0 && second_index == '0)
    else $error("non-detection result carries nonzero fields");

  a_leg_index_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && detected |-> second_index > first_index)
    else $error("second leg index not after first leg index");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(v[NUM_STAGES-1]))
    else $error("result appeared without a pipeline entry");

  a_backpressure_full: assert property (@(posedge clk) disable iff (rst)
    !sample_ready |-> (&v) && result_valid && !result_ready)
    else $error("sample input stalled while the pipeline had room");
`endif

endmodule

// ===== rtl/srpc_cfg.sv =====
// configuration register file behind the apb-style port
module srpc_cfg
  import srpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_reg_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thresh_level   <= RST_THRESHOLD;
      cfg.leg_separation <= RST_SEPARATION;
      cfg.start_angle    <= RST_START;
      cfg.angle_step     <= RST_STEP;
      cfg.range_floor    <= RST_FLOOR;
      cfg.range_ceiling  <= RST_CEILING;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_THRESHOLD:  cfg.thresh_level   <= pwdata[INT_W-1:0];
        REG_SEPARATION: cfg.leg_separation <= pwdata[SEP_W-1:0];
        REG_START:      cfg.start_angle    <= pwdata[ANG_W-1:0];
        REG_STEP:       cfg.angle_step     <= pwdata[STEP_W-1:0];
        REG_FLOOR:      cfg.range_floor    <= pwdata[RNG_W-1:0];
        REG_CEILING:    cfg.range_ceiling  <= pwdata[RNG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_THRESHOLD:  prdata = DATA_W'(cfg.thresh_level);
      REG_SEPARATION: prdata = DATA_W'(cfg.leg_separation);
      REG_START:      prdata = DATA_W'(cfg.start_angle);
      REG_STEP:       prdata = DATA_W'(cfg.angle_step);
      REG_FLOOR:      prdata = DATA_W'(cfg.range_floor);
      REG_CEILING:    prdata = DATA_W'(cfg.range_ceiling);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/srpc_scan.sv =====
// per-scan leg search and end-of-scan capture
module srpc_scan
  import srpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [INT_W-1:0] intensity,
  input  logic [RNG_W-1:0] range_mm,
  input  logic             range_finite,
  input  logic             last_sample,
  input  cfg_t             cfg,
  output snap_t            snap
);

  logic [CNT_W-1:0] sample_count;
  logic             first_found, second_found, first_range_ok, second_range_ok;
  logic [IDX_W-1:0] first_leg_pos, second_leg_pos;
  logic [RNG_W-1:0] first_leg_range, second_leg_range;

  logic             first_found_next, second_found_next;
  logic             first_range_ok_next, second_range_ok_next;
  logic [IDX_W-1:0] idx, gap;
  logic             in_window, reflective, range_ok, take_first, take_second;

  assign idx        = sample_count[IDX_W-1:0];
  assign gap        = idx - first_leg_pos;
  assign in_window  = sample_count < CNT_W'(MAX_SAMPLES);
  assign reflective = intensity >= cfg.thresh_level;
  assign range_ok   = range_finite && (range_mm >= cfg.range_floor)
                      && (range_mm <= cfg.range_ceiling);

  assign take_first  = in_window && reflective && !second_found && !first_found;
  assign take_second = in_window && reflective && !second_found && first_found
                       && (DIST_W'(gap) >= DIST_W'(cfg.leg_separation));

  assign first_found_next     = first_found || take_first;
  assign second_found_next    = second_found || take_second;
  assign first_range_ok_next  = take_first ? range_ok : first_range_ok;
  assign second_range_ok_next = take_second ? range_ok : second_range_ok;

  // view of the scan including the current sample
  always_comb begin
    snap.side.det = first_found_next && second_found_next
                    && first_range_ok_next && second_range_ok_next;
    snap.side.i1  = take_first ? idx : first_leg_pos;
    snap.side.i2  = take_second ? idx : second_leg_pos;
    snap.r1       = take_first ? range_mm : first_leg_range;
    snap.r2       = take_second ? range_mm : second_leg_range;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count    <= '0;
      first_found     <= 1'b0;
      second_found    <= 1'b0;
      first_range_ok  <= 1'b0;
      second_range_ok <= 1'b0;
    end else if (accept) begin
      if (last_sample) begin
        sample_count    <= '0;
        first_found     <= 1'b0;
        second_found    <= 1'b0;
        first_range_ok  <= 1'b0;
        second_range_ok <= 1'b0;
      end else begin
        if (in_window) begin
          sample_count <= CNT_W'(sample_count + 1'b1);
        end
        first_found     <= first_found_next;
        second_found    <= second_found_next;
        first_range_ok  <= first_range_ok_next;
        second_range_ok <= second_range_ok_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && take_first) begin
      first_leg_pos   <= idx;
      first_leg_range <= range_mm;
    end
    if (accept && take_second) begin
      second_leg_pos   <= idx;
      second_leg_range <= range_mm;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    accept && last_sample |=> sample_count == '0 && !first_found && !second_found)
    else $error("scan state not cleared after last sample");

  a_leg_order: assert property (@(posedge clk) disable iff (rst)
    second_found |-> first_found)
    else $error("second leg without first leg");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CNT_W'(MAX_SAMPLES))
    else $error("sample count past the scan limit");
`endif

endmodule

// ===== rtl/srpc_polar.sv =====
// pipelined polar to cartesian conversion of one leg
module srpc_polar
  import srpc_pkg::*;
(
  input  logic                    clk,
  input  logic [NUM_STAGES-1:0]   ld,
  input  cfg_t                    cfg,
  input  logic [RNG_W-1:0]        range_mm,
  input  logic [IDX_W-1:0]        index,
  output logic signed [XY_W-1:0]  x,
  output logic signed [XY_W-1:0]  y
);

  logic [AMUL_W-1:0] ang_prod;
  logic [RMUL_W-1:0] rng_prod;

  // multiply stage: beam angle offset and gain-scaled range
  always_ff @(posedge clk) begin
    if (ld[ST_MUL]) begin
      ang_prod <= AMUL_W'(index) * AMUL_W'(cfg.angle_step);
      rng_prod <= RMUL_W'(range_mm) * RMUL_W'(GAIN_Q30);
    end
  end

  logic [ANG_W-1:0]       angle, angle_f;
  logic                   fold;
  logic [RMUL_W:0]        rng_round;
  logic signed [XY_W-1:0] x_mag, x_init;
  logic signed [Z_W-1:0]  z_init;
  logic signed [XY_W-1:0] x_p, y_p;
  logic signed [Z_W-1:0]  z_p;

  // fold the left half plane onto the right half by a half turn
  always_comb begin
    angle     = cfg.start_angle + ANG_W'(ang_prod);
    fold      = angle[ANG_W-1] ^ angle[ANG_W-2];
    angle_f   = {angle[ANG_W-1] ^ fold, angle[ANG_W-2:0]};
    rng_round = {1'b0, rng_prod} + (RMUL_W+1)'(2**(RND_SHIFT-1));
    x_mag     = XY_W'(rng_round[RMUL_W:RND_SHIFT]);
    x_init    = fold ? -x_mag : x_mag;
    z_init    = {{(Z_W-ANG_W){angle_f[ANG_W-1]}}, angle_f};
  end

  always_ff @(posedge clk) begin
    if (ld[ST_PREP]) begin
      x_p <= x_init;
      y_p <= '0;
      z_p <= z_init;
    end
  end

  logic signed [XY_W-1:0] xr [CORDIC_STAGES];
  logic signed [XY_W-1:0] yr [CORDIC_STAGES];
  logic signed [Z_W-1:0]  zr [CORDIC_STAGES-1];

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_rot
    logic signed [XY_W-1:0] x_in, y_in, xv, yv, dx, dy;
    logic signed [Z_W-1:0]  z_in, zv;
    logic [Z_W-1:0]         at;

    if (s == 0) begin : g_first
      assign x_in = x_p;
      assign y_in = y_p;
      assign z_in = z_p;
    end else begin : g_next
      assign x_in = xr[s-1];
      assign y_in = yr[s-1];
      assign z_in = zr[s-1];
    end

    always_comb begin
      xv = x_in;
      yv = y_in;
      zv = z_in;
      dx = '0;
      dy = '0;
      at = '0;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        if (s * STEPS_PER_STAGE + k < CORDIC_STEPS) begin
          dx = yv >>> (s * STEPS_PER_STAGE + k);
          dy = xv >>> (s * STEPS_PER_STAGE + k);
          at = Z_W'(ATAN_TAB[s * STEPS_PER_STAGE + k]);
          if (zv[Z_W-1]) begin
            xv = xv + dx;
            yv = yv - dy;
            zv = zv + at;
          end else begin
            xv = xv - dx;
            yv = yv + dy;
            zv = zv - at;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ld[ST_ROT0 + s]) begin
        xr[s] <= xv;
        yr[s] <= yv;
      end
    end

    if (s < CORDIC_STAGES - 1) begin : g_zreg
      always_ff @(posedge clk) begin
        if (ld[ST_ROT0 + s]) begin
          zr[s] <= zv;
        end
      end
    end
  end

  assign x = xr[CORDIC_STAGES-1];
  assign y = yr[CORDIC_STAGES-1];

endmodule

// ===== rtl/srpc_mid.sv =====
// rounded midpoint of two q14 coordinates, saturated to the output range
module srpc_mid
  import srpc_pkg::*;
(
  input  logic signed [XY_W-1:0]  a,
  input  logic signed [XY_W-1:0]  b,
  output logic signed [CTR_W-1:0] mid
);

  logic signed [SUM_W-1:0] sum, half, hi, lo;

  always_comb begin
    hi   = SUM_W'(OUT_LIMIT);
    lo   = -hi;
    sum  = SUM_W'(a) + SUM_W'(b) + SUM_W'(2**FRAC_BITS);
    half = sum >>> (FRAC_BITS + 1);
    if (half > hi) begin
      mid = hi[CTR_W-1:0];
    end else if (half < lo) begin
      mid = lo[CTR_W-1:0];
    end else begin
      mid = half[CTR_W-1:0];
    end
  end

endmodule
